### sv/ebmlc_pkg.sv
`default_nettype none

package ebmlc_pkg;

  // program length; the core halts once the pc reaches it
  localparam int ProgramWords = 256;

  localparam int PcW    = 12;
  localparam int DataW  = 8;
  localparam int RegAw  = 3;
  localparam int MemAw  = 6;
  localparam int InstrW = 16;

  localparam int NumRegs  = 1 << RegAw;
  localparam int MemDepth = 1 << MemAw;

  // opcodes
  localparam logic [3:0] OP_RTYPE = 4'd0;
  localparam logic [3:0] OP_J     = 4'd2;
  localparam logic [3:0] OP_ADDI  = 4'd4;
  localparam logic [3:0] OP_BEQ   = 4'd8;
  localparam logic [3:0] OP_LW    = 4'd11;
  localparam logic [3:0] OP_SW    = 4'd15;

  // r-type funct codes
  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

endpackage

`default_nettype wire

### sv/eight_bit_mips_like_core.sv
// eight_bit_mips_like_core: small 8-bit core, one 16-bit instruction per transfer.
// Input channel (in_valid/in_ready/instruction) carries the word fetched at the
// current pc; the output channel (out_valid/out_ready plus result fields) returns
// one result per instruction: next_pc, halted, bad_opcode, register and store
// write info. The caller fetches the next word at next_pc.
// The synchronous register-file and data-store reads are registered into the
// execute stage at the input transfer edge; execute and write-back land in the
// output register when the execute stage advances, which a stalled receiver can
// hold off.
// Throughput: 1 instruction per cycle while the receiver keeps taking results;
// a write-back and the next instruction's reads share a cycle, and the register
// file and data store each forward their most recent write to cover the registered read.
// Reset clears pc, and the per-entry valid bits make all 8 registers and all 64
// data-store words read as zero; no clearing pass, in_ready is low during reset
// and inputs are taken from the first cycle after it.
// When the receiver stalls, the result holds in the output register, one more
// instruction waits in the execute stage, and in_ready drops until space frees.
// Once pc reaches the program length every result reports halted and no state
// changes.
`default_nettype none

module eight_bit_mips_like_core
  import ebmlc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [InstrW-1:0] instruction,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PcW-1:0]         next_pc,
  output logic                   halted,
  output logic                   bad_opcode,
  output logic                   reg_written,
  output logic [RegAw-1:0]       dest_reg,
  output logic [DataW-1:0]       write_value,
  output logic                   mem_written,
  output logic [MemAw-1:0]       mem_addr
);

  // storage
  logic [DataW-1:0] regs [NumRegs];
  logic [DataW-1:0] dmem [MemDepth];
  logic [NumRegs-1:0]  reg_ok;
  logic [MemDepth-1:0] dmem_ok;

  logic [PcW-1:0] pc;

  // execute stage
  logic              s1_valid;
  logic [InstrW-1:0] s1_instr;
  logic [DataW-1:0]  rs_q, rt_q, dm_q;
  logic              rs_ok_q, rt_ok_q, dm_ok_q;

  // most recent writes, forwarded to the read that shares their cycle
  logic             last_reg_we;
  logic [RegAw-1:0] last_reg_addr;
  logic [DataW-1:0] last_reg_data;
  logic             last_mem_we;
  logic [MemAw-1:0] last_mem_addr;
  logic [DataW-1:0] last_mem_data;

  logic in_xfer, s1_advance;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !rst && (!s1_valid || s1_advance);
  assign in_xfer    = in_valid && in_ready;

  // decode
  logic [3:0]       op;
  logic [RegAw-1:0] rs, rt, rd;
  logic [2:0]       fn;
  logic [MemAw-1:0] imm;
  logic [PcW-1:0]   target;

  assign op     = s1_instr[15:12];
  assign rs     = s1_instr[11:9];
  assign rt     = s1_instr[8:6];
  assign rd     = s1_instr[5:3];
  assign fn     = s1_instr[2:0];
  assign imm    = s1_instr[5:0];
  assign target = s1_instr[11:0];

  logic [DataW-1:0] rs_val, rt_val, ld_val;

  always_comb begin
    if (last_reg_we && last_reg_addr == rs) rs_val = last_reg_data;
    else rs_val = rs_ok_q ? rs_q : '0;
    if (last_reg_we && last_reg_addr == rt) rt_val = last_reg_data;
    else rt_val = rt_ok_q ? rt_q : '0;
    if (last_mem_we && last_mem_addr == imm) ld_val = last_mem_data;
    else ld_val = dm_ok_q ? dm_q : '0;
  end

  // execute
  logic [PcW-1:0]   npc;
  logic             ex_halted, ex_bad, rf_we, dm_we;
  logic [RegAw-1:0] ex_dreg;
  logic [DataW-1:0] ex_wval;
  logic [MemAw-1:0] ex_maddr;

  always_comb begin
    npc       = pc + PcW'(1);
    ex_halted = 1'b0;
    ex_bad    = 1'b0;
    rf_we     = 1'b0;
    dm_we     = 1'b0;
    ex_dreg   = '0;
    ex_wval   = '0;
    ex_maddr  = '0;
    if ({1'b0, pc} >= (PcW+1)'(ProgramWords)) begin
      ex_halted = 1'b1;
      npc       = pc;
    end else begin
      case (op)
        OP_RTYPE: begin
          rf_we   = 1'b1;
          ex_dreg = rd;
          case (fn)
            FN_ADD:  ex_wval = rs_val + rt_val;
            FN_SUB:  ex_wval = rs_val - rt_val;
            FN_AND:  ex_wval = rs_val & rt_val;
            FN_OR:   ex_wval = rs_val | rt_val;
            default: begin
              rf_we   = 1'b0;
              ex_dreg = '0;
            end
          endcase
        end
        OP_ADDI: begin
          rf_we   = 1'b1;
          ex_dreg = rt;
          ex_wval = rs_val + DataW'(imm);
        end
        OP_LW: begin
          rf_we    = 1'b1;
          ex_dreg  = rt;
          ex_wval  = ld_val;
          ex_maddr = imm;
        end
        OP_SW: begin
          dm_we    = 1'b1;
          ex_wval  = rt_val;
          ex_maddr = imm;
        end
        OP_BEQ: begin
          if (rs_val == rt_val) npc = pc + PcW'(imm) + PcW'(1);
        end
        OP_J: begin
          npc = target;
        end
        default: begin
          ex_bad = 1'b1;
        end
      endcase
    end
  end

  // memory arrays: one write and synchronous reads
  always_ff @(posedge clk) begin
    if (s1_advance && rf_we) regs[ex_dreg] <= ex_wval;
    if (s1_advance && dm_we) dmem[imm] <= ex_wval;
    if (in_xfer) begin
      rs_q     <= regs[instruction[11:9]];
      rt_q     <= regs[instruction[8:6]];
      dm_q     <= dmem[instruction[5:0]];
      rs_ok_q  <= reg_ok[instruction[11:9]];
      rt_ok_q  <= reg_ok[instruction[8:6]];
      dm_ok_q  <= dmem_ok[instruction[5:0]];
      s1_instr <= instruction;
    end
  end

  // control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= '0;
      reg_ok      <= '0;
      dmem_ok     <= '0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      last_reg_we <= 1'b0;
      last_mem_we <= 1'b0;
    end else begin
      if (in_xfer) s1_valid <= 1'b1;
      else if (s1_advance) s1_valid <= 1'b0;

      if (s1_advance) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (s1_advance) begin
        pc <= npc;
        if (rf_we) begin
          reg_ok[ex_dreg] <= 1'b1;
          last_reg_we     <= 1'b1;
          last_reg_addr   <= ex_dreg;
          last_reg_data   <= ex_wval;
        end
        if (dm_we) begin
          dmem_ok[imm]  <= 1'b1;
          last_mem_we   <= 1'b1;
          last_mem_addr <= imm;
          last_mem_data <= ex_wval;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      next_pc     <= npc;
      halted      <= ex_halted;
      bad_opcode  <= ex_bad;
      reg_written <= rf_we;
      dest_reg    <= ex_dreg;
      write_value <= ex_wval;
      mem_written <= dm_we;
      mem_addr    <= ex_maddr;
    end
  end

  // a held result with a full execute stage blocks the input
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline is full");

  // a halted step never writes anything
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(halted && (reg_written || mem_written)))
    else $error("halted step wrote state");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(reg_written && mem_written))
    else $error("register and store written in one step");

  // a register write is recorded for forwarding in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s1_advance && rf_we) |=> (last_reg_we && last_reg_addr == $past(ex_dreg)))
    else $error("register write not captured for forwarding");

  // pc only moves when an instruction completes
  assert property (@(posedge clk) disable iff (rst)
    !s1_advance |=> $stable(pc))
    else $error("pc changed without a completed instruction");

endmodule

`default_nettype wire

### test/eight_bit_mips_like_core_checker.sv
`timescale 1ns / 100ps

module eight_bit_mips_like_core_checker
  import ebmlc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [InstrW-1:0] instruction,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [PcW-1:0]    next_pc,
  input  wire logic              halted,
  input  wire logic              bad_opcode,
  input  wire logic              reg_written,
  input  wire logic [RegAw-1:0]  dest_reg,
  input  wire logic [DataW-1:0]  write_value,
  input  wire logic              mem_written,
  input  wire logic [MemAw-1:0]  mem_addr,
  output int                     mismatches,
  output int                     results_outstanding,
  output logic [PcW-1:0]         core_pc,
  output int                     results_checked,
  output int                     halted_count,
  output int                     bad_op_count,
  output int                     taken_count
);

  typedef struct packed {
    logic [InstrW-1:0] word;
    logic [PcW-1:0]    pc_after;
    logic              halt;
    logic              bad;
    logic              reg_wr;
    logic [RegAw-1:0]  dest;
    logic [DataW-1:0]  wdata;
    logic              mem_wr;
    logic [MemAw-1:0]  maddr;
  } step_result_t;

  logic [PcW-1:0]   pc_q;
  logic [DataW-1:0] gpr [NumRegs];
  logic [DataW-1:0] dmem [MemDepth];
  step_result_t     step_q[$];

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // four-state compare so unknown outputs are caught
  task automatic check_field(input logic [InstrW-1:0] word, input string name,
                             input logic [31:0] seen, input logic [31:0] wanted);
    if (seen !== wanted)
      report_mismatch($sformatf("instr %h: %s is %0d, expected %0d",
                                word, name, seen, wanted));
  endtask

  // executes one instruction against the shadow state
  function automatic step_result_t execute_word(input logic [InstrW-1:0] word);
    step_result_t     r;
    logic [3:0]       op;
    logic [RegAw-1:0] rs;
    logic [RegAw-1:0] rt;
    logic [RegAw-1:0] rd;
    logic [2:0]       fn;
    logic [MemAw-1:0] imm;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    op  = word[15:12];
    rs  = word[11:9];
    rt  = word[8:6];
    rd  = word[5:3];
    fn  = word[2:0];
    imm = word[5:0];
    r = '0;
    r.word = word;
    if (pc_q >= ProgramWords) begin
      r.halt = 1'b1;
      r.pc_after = pc_q;
      return r;
    end
    r.pc_after = pc_q + 1'b1;
    a = gpr[rs];
    b = gpr[rt];
    case (op)
      OP_RTYPE: begin
        r.reg_wr = 1'b1;
        case (fn)
          FN_ADD: r.wdata = a + b;
          FN_SUB: r.wdata = a - b;
          FN_AND: r.wdata = a & b;
          FN_OR:  r.wdata = a | b;
          default: r.reg_wr = 1'b0;
        endcase
        if (r.reg_wr) begin
          r.dest = rd;
          gpr[rd] = r.wdata;
        end
      end
      OP_ADDI: begin
        r.reg_wr = 1'b1;
        r.dest = rt;
        r.wdata = a + imm;
        gpr[rt] = r.wdata;
      end
      OP_LW: begin
        r.reg_wr = 1'b1;
        r.dest = rt;
        r.wdata = dmem[imm];
        r.maddr = imm;
        gpr[rt] = r.wdata;
      end
      OP_SW: begin
        r.mem_wr = 1'b1;
        r.wdata = b;
        r.maddr = imm;
        dmem[imm] = b;
      end
      OP_BEQ: begin
        if (a == b) begin
          r.pc_after = pc_q + imm + 1'b1;
          taken_count++;
        end
      end
      OP_J: r.pc_after = word[11:0];
      default: r.bad = 1'b1;
    endcase
    pc_q = r.pc_after;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    step_result_t want;
    if (rst) begin
      pc_q = '0;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      step_q.delete();
      mismatches = 0;
      results_checked = 0;
      halted_count = 0;
      bad_op_count = 0;
      taken_count = 0;
      core_pc <= '0;
      results_outstanding <= 0;
    end else begin
      if (in_valid && in_ready)
        step_q.push_back(execute_word(instruction));
      if (out_valid && out_ready) begin
        results_checked++;
        if (step_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing pending, next_pc %0d",
                                    next_pc));
        end else begin
          want = step_q.pop_front();
          if (want.halt) halted_count++;
          if (want.bad) bad_op_count++;
          check_field(want.word, "next_pc", 32'(next_pc), 32'(want.pc_after));
          check_field(want.word, "halted", 32'(halted), 32'(want.halt));
          check_field(want.word, "bad_opcode", 32'(bad_opcode), 32'(want.bad));
          check_field(want.word, "reg_written", 32'(reg_written), 32'(want.reg_wr));
          check_field(want.word, "dest_reg", 32'(dest_reg), 32'(want.dest));
          check_field(want.word, "write_value", 32'(write_value), 32'(want.wdata));
          check_field(want.word, "mem_written", 32'(mem_written), 32'(want.mem_wr));
          check_field(want.word, "mem_addr", 32'(mem_addr), 32'(want.maddr));
        end
      end
      core_pc <= pc_q;
      results_outstanding <= step_q.size();
    end
  end

endmodule

### test/eight_bit_mips_like_core_tb.sv
`timescale 1ns / 100ps

module eight_bit_mips_like_core_tb;
  import ebmlc_pkg::*;

  localparam int RandomItems = 1700;
  // random programs jump back once the pc passes this; the view of the pc lags
  // by one instruction, so two branches of at most 64 still stay below the end
  localparam int SafePc = 100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic [InstrW-1:0] instruction = '0;
  logic              out_ready = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [PcW-1:0]    next_pc;
  logic              halted;
  logic              bad_opcode;
  logic              reg_written;
  logic [RegAw-1:0]  dest_reg;
  logic [DataW-1:0]  write_value;
  logic              mem_written;
  logic [MemAw-1:0]  mem_addr;

  int             mismatches;
  int             results_outstanding;
  logic [PcW-1:0] core_pc;
  int             results_checked;
  int             halted_count;
  int             bad_op_count;
  int             taken_count;
  int             items_sent = 0;
  int             stall_cycle = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  eight_bit_mips_like_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .instruction (instruction),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .next_pc     (next_pc),
    .halted      (halted),
    .bad_opcode  (bad_opcode),
    .reg_written (reg_written),
    .dest_reg    (dest_reg),
    .write_value (write_value),
    .mem_written (mem_written),
    .mem_addr    (mem_addr)
  );

  eight_bit_mips_like_core_checker u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .instruction         (instruction),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .next_pc             (next_pc),
    .halted              (halted),
    .bad_opcode          (bad_opcode),
    .reg_written         (reg_written),
    .dest_reg            (dest_reg),
    .write_value         (write_value),
    .mem_written         (mem_written),
    .mem_addr            (mem_addr),
    .mismatches          (mismatches),
    .results_outstanding (results_outstanding),
    .core_pc             (core_pc),
    .results_checked     (results_checked),
    .halted_count        (halted_count),
    .bad_op_count        (bad_op_count),
    .taken_count         (taken_count)
  );

  // receiver: always ready, then mostly ready, then mostly stalled
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if ((stall_cycle / 300) % 3 == 0) begin
      out_ready <= 1'b1;
    end else if ((stall_cycle / 300) % 3 == 1) begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready <= ($urandom_range(0, 4) == 0);
    end
  end

  function automatic logic [InstrW-1:0] encode(input logic [3:0] op,
                                               input logic [RegAw-1:0] rs,
                                               input logic [RegAw-1:0] rt,
                                               input logic [5:0] low);
    return {op, rs, rt, low};
  endfunction

  function automatic logic [InstrW-1:0] pick_word(input logic [PcW-1:0] pc_view);
    logic [InstrW-1:0] w;
    int                roll;
    w = InstrW'($urandom);
    roll = $urandom_range(0, 99);
    if (pc_view >= SafePc) begin
      w[15:12] = OP_J;
    end else if (roll < 30) begin
      w[15:12] = OP_RTYPE;
      case ($urandom_range(0, 3))
        0: w[2:0] = FN_ADD;
        1: w[2:0] = FN_SUB;
        2: w[2:0] = FN_AND;
        default: w[2:0] = FN_OR;
      endcase
    end else if (roll < 42) begin
      w[15:12] = OP_ADDI;
    end else if (roll < 54) begin
      w[15:12] = OP_LW;
    end else if (roll < 66) begin
      w[15:12] = OP_SW;
    end else if (roll < 78) begin
      w[15:12] = OP_BEQ;
      if ($urandom_range(0, 2) == 0) w[8:6] = w[11:9];
    end else if (roll < 82) begin
      w[15:12] = OP_J;
    end else if (roll < 88) begin
      w[15:12] = OP_RTYPE;
    end
    if (w[15:12] == OP_J) w[11:0] = PcW'($urandom_range(0, SafePc - 1));
    return w;
  endfunction

  task automatic send_word(input logic [InstrW-1:0] word);
    in_valid <= 1'b1;
    instruction <= word;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  initial begin
    logic [InstrW-1:0] directed_q[$];
    int                burst_left;
    directed_q.push_back(encode(OP_ADDI, 0, 7, '1));
    directed_q.push_back(encode(OP_ADDI, 7, 7, '1));
    directed_q.push_back(encode(OP_RTYPE, 7, 7, {3'd6, FN_ADD}));
    // every funct, known and unknown, on values that wrap
    for (int f = 0; f < 8; f++)
      directed_q.push_back(encode(OP_RTYPE, 6, 7, {3'd5, 3'(f)}));
    directed_q.push_back(encode(OP_RTYPE, 0, 7, {3'd4, FN_SUB}));
    directed_q.push_back(encode(OP_SW, 0, 7, '1));
    directed_q.push_back(encode(OP_LW, 0, 1, '1));
    directed_q.push_back(encode(OP_LW, 0, 2, '0));
    directed_q.push_back(encode(OP_BEQ, 1, 7, '1));
    directed_q.push_back(encode(OP_BEQ, 1, 2, '1));
    for (int op = 0; op < 16; op++) begin
      case (4'(op))
        OP_RTYPE, OP_J, OP_ADDI, OP_BEQ, OP_LW, OP_SW: ;
        default: directed_q.push_back(encode(4'(op), 5, 3, 6'h2A));
      endcase
    end
    directed_q.push_back(encode(OP_J, 0, 0, '0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_q[i]) send_word(directed_q[i]);

    burst_left = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) begin
        // hold off until every result is back
        in_valid <= 1'b0;
        do @(posedge clk); while (results_outstanding != 0);
      end else if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 60);
      end
      burst_left--;
      send_word(pick_word(core_pc));
    end

    // run off the end of the program, then keep issuing while halted
    send_word({OP_J, PcW'(ProgramWords - 1)});
    send_word(encode(OP_ADDI, 3, 4, '1));
    send_word({OP_J, {PcW{1'b1}}});
    repeat (4) send_word(InstrW'($urandom));

    in_valid <= 1'b0;
    do @(posedge clk); while (results_outstanding != 0);
    repeat (20) @(posedge clk);

    $display("sent %0d instructions, checked %0d results", items_sent, results_checked);
    $display("covered %0d taken branches, %0d unknown opcodes, %0d halted steps",
             taken_count, bad_op_count, halted_count);
    if (mismatches == 0) begin
      $display("eight_bit_mips_like_core_tb passed");
    end else begin
      $display("eight_bit_mips_like_core_tb failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout waiting for a transfer");
    $display("eight_bit_mips_like_core_tb failed");
    $finish;
  end

endmodule
